/* design/s2a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_pkg: shared constants for the signed integer to decimal text converter.
// Holds the ASCII codes, the digit count and the stage-to-stage control struct.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned IdxWidth   = 4;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  // Control that travels beside the data through the conversion pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
  } stage_ctl_t;

endpackage

/* design/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: prints a signed 32-bit value as decimal ASCII.
//
// The slave channel takes one two's complement value per transaction on
// s_axis_tdata. The master channel gives one character per transaction on
// m_axis_tdata, most significant digit first, with a leading '-' for a
// negative value and no leading zeros; m_axis_tlast marks the final character.
// The most negative value prints through its unsigned magnitude.
//
// The magnitude is converted by a capture stage and a shift-and-add-3 (double
// dabble) pipeline of 32 register stages, one bit per stage, so a value may
// enter every cycle the pipeline moves. A separate emitter then sends 1 to 11
// characters, one per cycle while the receiver accepts them. The sustained
// rate is set by the emitter, which loads each value from the last stage
// first; the pipeline keeps taking values until its last stage holds one.
// When the receiver stalls, the emitter holds its character; the pipeline
// freezes once its last stage holds a value, so nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all valid bits and the emitter.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast    // last
);
  import s2a_pkg::*;

  localparam int unsigned Stages = ValueWidth;

  // Pipeline registers: remaining binary bits and the BCD digits so far.
  stage_ctl_t                  ctl [Stages+1];
  logic [ValueWidth-1:0]       bin [Stages+1];
  logic [BcdWidth-1:0]         bcd [Stages+1];

  // Emitter state.
  logic                 busy;
  logic                 sign_pend;
  logic [BcdWidth-1:0]  digits;
  logic [IdxWidth-1:0]  idx;
  logic                 advance;
  logic                 emit_done;

  assign advance       = !ctl[Stages].valid || (!busy);
  assign s_axis_tready = advance;

  // Stage 0 captures the magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
      ctl[0].neg   <= 1'b0;
    end else if (advance) begin
      ctl[0].valid <= s_axis_tvalid;
      ctl[0].neg   <= s_axis_tdata[ValueWidth-1];
    end
    if (advance) begin
      bin[0] <= s_axis_tdata[ValueWidth-1] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
      bcd[0] <= '0;
    end
  end

  // One double dabble step per stage: adjust each digit, then shift in a bit.
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [BcdWidth-1:0] adj;
    always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
        adj[4*d +: 4] = (bcd[s][4*d +: 4] > 4'd4) ? bcd[s][4*d +: 4] + 4'd3
                                                   : bcd[s][4*d +: 4];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
        ctl[s+1].neg   <= 1'b0;
      end else if (advance) begin
        ctl[s+1] <= ctl[s];
      end
      if (advance) begin
        bcd[s+1] <= {adj[BcdWidth-2:0], bin[s][ValueWidth-1]};
        bin[s+1] <= {bin[s][ValueWidth-2:0], 1'b0};
      end
    end
  end

  // Index of the leading nonzero digit (zero prints one digit).
  logic [IdxWidth-1:0] top_idx;
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[Stages][4*d +: 4] != 4'd0) top_idx = IdxWidth'(d);
    end
  end

  // Character emitter.
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = sign_pend ? AsciiMinus : (AsciiZero + {4'd0, digits[4*idx +: 4]});
  assign m_axis_tlast  = !sign_pend && (idx == '0);
  assign emit_done     = busy && m_axis_tready && m_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
    end else if (!busy) begin
      if (ctl[Stages].valid) begin
        busy      <= 1'b1;
        sign_pend <= ctl[Stages].neg;
      end
    end else if (m_axis_tready) begin
      if (sign_pend) sign_pend <= 1'b0;
      else if (idx == '0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && ctl[Stages].valid) begin
      digits <= bcd[Stages];
      idx    <= top_idx;
    end else if (busy && m_axis_tready && !sign_pend && idx != '0) begin
      idx <= idx - 4'd1;
    end
  end

  // Assertions.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    busy && !sign_pend |-> digits[4*idx +: 4] <= 4'd9)
    else $error("digit out of decimal range");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy && ctl[Stages].valid |-> !s_axis_tready)
    else $error("pipeline advanced while emitter holds an item");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    emit_done |=> !busy)
    else $error("emitter stayed busy after last character");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < 4'd10)
    else $error("digit index out of range");

endmodule
